// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker of the status LED controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Condition that must never be seen on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error(msg);

`endif

// ===== design/slbc_pkg.sv =====
// Types, constants and helper functions of the status LED blink controller.
package slbc_pkg;

  localparam int LEDS_PER_STRIP = 16;
  localparam int ENTRIES        = 2 * LEDS_PER_STRIP;
  localparam int MAX_RESULTS    = 32;
  localparam int TICK_N         = (ENTRIES < MAX_RESULTS) ? ENTRIES : MAX_RESULTS;
  localparam int ADDR_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LED_W          = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
  localparam int COLOR_W        = 24;
  localparam int LEDNUM_W       = 7;
  localparam int MODE_W         = 3;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_STATUS   = 3'd0,
    MODE_SET_COLOR    = 3'd1,
    MODE_STRIP_COLOR  = 3'd2,
    MODE_STRIP_STATUS = 3'd3,
    MODE_TICK         = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ERROR = 3'd0,
    ST_OK    = 3'd1,
    ST_DATA  = 3'd2,
    ST_LOAD  = 3'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERROR_COLOR = 2'd0,
    CFG_OK_COLOR    = 2'd1,
    CFG_DATA_COLOR  = 2'd2,
    CFG_LOAD_COLOR  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                strip;
    logic [LEDNUM_W-1:0] led_number;
    logic [STATUS_W-1:0] status;
    logic [COLOR_W-1:0]  color;
  } in_t;

  typedef struct packed {
    logic                out_strip;
    logic [LEDNUM_W-1:0] out_led;
    logic [COLOR_W-1:0]  wire_word;
    logic                last;
  } out_t;

  typedef struct packed {
    logic [COLOR_W-1:0] error_color;
    logic [COLOR_W-1:0] ok_color;
    logic [COLOR_W-1:0] data_color;
    logic [COLOR_W-1:0] load_color;
  } colors_t;

  typedef logic [LED_W-1:0] led_mod_tbl_t [2**LEDNUM_W];

  // Folds a raw LED number into the strip; evaluated once at elaboration.
  function automatic led_mod_tbl_t gen_led_mod_tbl();
    led_mod_tbl_t tbl;
    for (int i = 0; i < 2**LEDNUM_W; i++) begin
      tbl[i] = LED_W'(i % LEDS_PER_STRIP);
    end
    return tbl;
  endfunction

  localparam led_mod_tbl_t LED_MOD_TBL = gen_led_mod_tbl();

  function automatic logic [COLOR_W-1:0] status_color(colors_t c, logic [STATUS_W-1:0] st);
    logic [COLOR_W-1:0] col;
    unique case (st)
      ST_ERROR: col = c.error_color;
      ST_OK:    col = c.ok_color;
      ST_DATA:  col = c.data_color;
      ST_LOAD:  col = c.load_color;
      default:  col = '0;
    endcase
    return col;
  endfunction

  // RGB with red on top becomes green, red, blue in send order.
  function automatic logic [COLOR_W-1:0] to_wire(logic [COLOR_W-1:0] rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(logic strip, logic [LED_W-1:0] led);
    logic [ADDR_W-1:0] base;
    base = strip ? ADDR_W'(LEDS_PER_STRIP) : '0;
    return base + ADDR_W'(led);
  endfunction

endpackage

// ===== design/slbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module slbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/slbc_regs.sv =====
// Configuration registers holding the status colors.
module slbc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [slbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [slbc_pkg::COLOR_W-1:0]    cfg_data_i,
  output slbc_pkg::colors_t               colors_o
);
  import slbc_pkg::*;

  colors_t colors_q, colors_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    colors_d = colors_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ERROR_COLOR: colors_d.error_color = cfg_data_i;
        CFG_OK_COLOR:    colors_d.ok_color    = cfg_data_i;
        CFG_DATA_COLOR:  colors_d.data_color  = cfg_data_i;
        CFG_LOAD_COLOR:  colors_d.load_color  = cfg_data_i;
        default:         colors_d = colors_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q <= '0;
    end else begin
      colors_q <= colors_d;
    end
  end

  assign colors_o = colors_q;

endmodule

// ===== design/slbc_seq.sv =====
// Command sequencer: color memories, sweeps over the LEDs and the output register.
module slbc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slbc_pkg::colors_t colors_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  slbc_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output slbc_pkg::out_t    out_data_o
);
  import slbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WRITE = 3'b010,
    S_TICK  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Command context for single writes and strip sweeps.
  logic               cmd_strip_q, cmd_strip_d;
  logic [COLOR_W-1:0] cmd_color_q, cmd_color_d;
  logic [LED_W-1:0]   cnt_q, cnt_d;
  logic [LED_W-1:0]   end_q, end_d;

  // Tick sweep: read issue index and the entry whose read data is out.
  logic [ADDR_W-1:0]  tk_q, tk_d;
  logic               iss_done_q, iss_done_d;
  logic               rd_vld_q, rd_vld_d;
  logic [ADDR_W-1:0]  rd_idx_q;
  logic               rd_strip_q;
  logic [LED_W-1:0]   rd_led_q;
  logic               rd_last_q;

  logic [ENTRIES-1:0] svalid_q, svalid_d;
  logic [ENTRIES-1:0] pvalid_q, pvalid_d;

  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               out_free, step, issue, consume;
  logic [LED_W-1:0]   led_mod;
  logic [ADDR_W-1:0]  step_addr;
  logic               tk_strip, tk_last;
  logic [ADDR_W-1:0]  tk_off;
  logic [LED_W-1:0]   tk_led;
  logic               pend_we;
  logic [ADDR_W-1:0]  pend_waddr;
  logic [COLOR_W-1:0] s_rdata, p_rdata, pend_col, stdy_col, show_col;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign led_mod    = LED_MOD_TBL[in_data_i.led_number];

  assign step      = (state_q == S_WRITE) && out_free;
  assign step_addr = slot_addr(cmd_strip_q, cnt_q);

  // A read is issued when no entry waits or the entry ahead of it leaves in the same cycle.
  assign issue   = (state_q == S_TICK) && !iss_done_q && (!rd_vld_q || out_free);
  assign consume = rd_vld_q && out_free;

  assign tk_strip = (tk_q >= ADDR_W'(LEDS_PER_STRIP));
  assign tk_off   = tk_strip ? ADDR_W'(LEDS_PER_STRIP) : '0;
  assign tk_led   = LED_W'(tk_q - tk_off);
  assign tk_last  = (tk_q == ADDR_W'(TICK_N - 1));

  assign pend_we = (state_q == S_IDLE) && in_valid_i
                && (in_data_i.mode == MODE_SET_STATUS) && (in_data_i.status == ST_DATA);
  assign pend_waddr = slot_addr(in_data_i.strip, led_mod);

  slbc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (ENTRIES)
  ) u_steady_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (step_addr),
    .wdata_i (cmd_color_q),
    .re_i    (issue),
    .raddr_i (tk_q),
    .rdata_o (s_rdata)
  );

  slbc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (ENTRIES)
  ) u_pending_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (colors_i.data_color),
    .re_i    (issue),
    .raddr_i (tk_q),
    .rdata_o (p_rdata)
  );

  // Entries never written read as black; a zero pending color means no blink.
  assign pend_col = pvalid_q[rd_idx_q] ? p_rdata : '0;
  assign stdy_col = svalid_q[rd_idx_q] ? s_rdata : '0;
  assign show_col = (pend_col != '0) ? pend_col : stdy_col;

  always_comb begin
    state_d     = state_q;
    cmd_strip_d = cmd_strip_q;
    cmd_color_d = cmd_color_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    tk_d        = tk_q;
    iss_done_d  = iss_done_q;
    svalid_d    = svalid_q;
    pvalid_d    = pvalid_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_strip_d = in_data_i.strip;
          cnt_d       = led_mod;
          end_d       = led_mod;
          unique case (in_data_i.mode)
            MODE_SET_STATUS: begin
              if ((in_data_i.status == ST_ERROR) || (in_data_i.status == ST_OK)
                  || (in_data_i.status == ST_LOAD)) begin
                cmd_color_d = status_color(colors_i, in_data_i.status);
                state_d     = S_WRITE;
              end else if (in_data_i.status == ST_DATA) begin
                pvalid_d[pend_waddr] = 1'b1;
              end
            end
            MODE_SET_COLOR: begin
              cmd_color_d = in_data_i.color;
              state_d     = S_WRITE;
            end
            MODE_STRIP_COLOR: begin
              cmd_color_d = in_data_i.color;
              cnt_d       = '0;
              end_d       = LED_W'(LEDS_PER_STRIP - 1);
              state_d     = S_WRITE;
            end
            MODE_STRIP_STATUS: begin
              cmd_color_d = status_color(colors_i, in_data_i.status);
              cnt_d       = '0;
              end_d       = LED_W'(LEDS_PER_STRIP - 1);
              state_d     = S_WRITE;
            end
            MODE_TICK: begin
              tk_d       = '0;
              iss_done_d = 1'b0;
              state_d    = S_TICK;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_WRITE: begin
        if (step) begin
          svalid_d[step_addr] = 1'b1;
          if (cnt_q == end_q) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_TICK: begin
        if (issue) begin
          tk_d = tk_q + 1'b1;
          if (tk_last) begin
            iss_done_d = 1'b1;
          end
        end
        if (consume) begin
          if (pend_col != '0) begin
            pvalid_d[rd_idx_q] = 1'b0;
          end
          if (rd_last_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_vld_d = rd_vld_q;
    if (issue) begin
      rd_vld_d = 1'b1;
    end else if (consume) begin
      rd_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step) begin
      out_valid_d     = 1'b1;
      out_d.out_strip = cmd_strip_q;
      out_d.out_led   = LEDNUM_W'(cnt_q);
      out_d.wire_word = to_wire(cmd_color_q);
      out_d.last      = (cnt_q == end_q);
    end else if (consume) begin
      out_valid_d     = 1'b1;
      out_d.out_strip = rd_strip_q;
      out_d.out_led   = LEDNUM_W'(rd_led_q);
      out_d.wire_word = to_wire(show_col);
      out_d.last      = rd_last_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_done_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
      svalid_q    <= '0;
      pvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_done_q  <= iss_done_d;
      rd_vld_q    <= rd_vld_d;
      svalid_q    <= svalid_d;
      pvalid_q    <= pvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_strip_q <= cmd_strip_d;
    cmd_color_q <= cmd_color_d;
    cnt_q       <= cnt_d;
    end_q       <= end_d;
    tk_q        <= tk_d;
    out_q       <= out_d;
    if (issue) begin
      rd_idx_q   <= tk_q;
      rd_strip_q <= tk_strip;
      rd_led_q   <= tk_led;
      rd_last_q  <= tk_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/status_led_blink_controller_core.sv =====
// Top level of the status LED blink controller for two RGB LED strips.
//
// Commands enter on in_valid_i/in_stall_o with an in_t payload; one
// transaction is taken at an edge where in_valid_i is high and in_stall_o low.
// Each LED update leaves on out_valid_o/out_stall_i as an out_t transaction;
// the last update caused by a command carries last set.
// Status colors are written through cfg_valid_i/cfg_ready_o while idle; the
// user must keep to this, as the block does not enforce it. A single-LED
// command writes its result to the output register once that is free and is
// idle again in the same cycle; setting the data status only marks a pending
// blink, with no result. A strip command gives LEDS_PER_STRIP results and a
// tick, which sweeps both strips through the steady and pending color memories
// and their registered read, gives 32; each gives one per cycle while the
// receiver does not stall. A new command is taken as soon as the sweep has
// filled the output register, even while its last result still waits there.
// When the receiver stalls, the output register holds and the sweep pauses.
// Reset clears the status colors and the per-entry valid bits, so every LED
// reads black with no blink pending; no clearing pass is needed.
module status_led_blink_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  slbc_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output slbc_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [slbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [slbc_pkg::COLOR_W-1:0]   cfg_data_i
);
  import slbc_pkg::*;

  colors_t colors;

  slbc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .colors_o    (colors)
  );

  slbc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .colors_i    (colors),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/slbc_checker.sv =====
// Port-level checker for the status LED blink controller and its bind.
`include "assert_macros.svh"

module slbc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input slbc_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input slbc_pkg::out_t out_data_o
);
  import slbc_pkg::*;

  `ASSERT_PROP(a_out_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")
  `ASSERT_PROP(a_out_data_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_data_o), "stalled result changed")
  `ASSERT_PROP(a_tick_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.mode == MODE_TICK) |=> in_stall_o, "tick did not occupy the block")
  `ASSERT_PROP(a_mid_busy, clk_i, rst_ni, out_valid_o && !out_data_o.last |-> in_stall_o, "block idle before the final result")
  `ASSERT_NEVER(a_led_range, clk_i, rst_ni, out_valid_o && (out_data_o.out_led >= LEDNUM_W'(LEDS_PER_STRIP)), "LED index beyond strip length")

endmodule

bind status_led_blink_controller_core slbc_checker u_slbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
